>>> rtl/core/olc_pkg.sv
// Shared types, constants and helper functions of the occupancy light controller.
// No dependencies; used by olc_core, olc_display and occupancy_light_controller.
package olc_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned CntW   = 7;
  localparam int unsigned NumBtn = 3;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 16;
  localparam int unsigned SegW   = 8;

  // Button positions in the raw button vector.
  localparam int unsigned BtnSensor = 0;
  localparam int unsigned BtnLight  = 1;
  localparam int unsigned BtnReset  = 2;

  localparam logic [CntW-1:0] CountMax = 7'd99;

  // Register reset values.
  localparam logic [TickW-1:0] PeriodTicksRst   = 16'd50000;
  localparam logic [CntW-1:0]  PeriodCountRst   = 7'd100;
  localparam logic [TickW-1:0] DebounceTicksRst = 16'd20000;
  localparam logic [CntW-1:0]  GreenLimitRst    = 7'd10;
  localparam logic [CntW-1:0]  YellowLimitRst   = 7'd20;

  typedef enum logic [IdxW-1:0] {
    RegPeriodTicks   = 3'd0,
    RegPeriodCount   = 3'd1,
    RegDebounceTicks = 3'd2,
    RegGreenLimit    = 3'd3,
    RegYellowLimit   = 3'd4
  } olc_reg_e;

  typedef struct packed {
    logic [TickW-1:0] period_ticks;
    logic [CntW-1:0]  period_count;
    logic [TickW-1:0] debounce_ticks;
    logic [CntW-1:0]  green_limit;
    logic [CntW-1:0]  yellow_limit;
  } olc_cfg_t;

  typedef struct packed {
    logic            light;
    logic            sensor_en;
    logic            holding;
    logic [CntW-1:0] count;
  } olc_status_t;

  typedef struct packed {
    logic            green;
    logic            yellow;
    logic            red;
    logic [SegW-1:0] seg_tens;
    logic [SegW-1:0] seg_units;
  } olc_disp_t;

  typedef struct packed {
    logic             fire;
    logic [TickW-1:0] timer;
    logic             await_rel;
  } olc_deb_t;

  // One tick of a button debouncer: act once the press has lasted the limit.
  function automatic olc_deb_t debounce_step(input logic             pressed,
                                             input logic [TickW-1:0] timer,
                                             input logic             await_rel,
                                             input logic [TickW-1:0] limit);
    olc_deb_t res;
    res.fire      = 1'b0;
    res.timer     = timer;
    res.await_rel = await_rel;
    if (!pressed) begin
      res.timer     = '0;
      res.await_rel = 1'b0;
    end else if (!await_rel) begin
      if (timer >= limit) begin
        res.timer     = '0;
        res.await_rel = 1'b1;
        res.fire      = 1'b1;
      end else begin
        res.timer = timer + 16'd1;
      end
    end
    return res;
  endfunction

  // Saturating event count increment.
  function automatic logic [CntW-1:0] count_inc(input logic [CntW-1:0] c);
    return (c < CountMax) ? c + 7'd1 : c;
  endfunction

  // Tens digit of a count in 0..99 by a compare chain.
  function automatic logic [3:0] tens_of(input logic [CntW-1:0] c);
    logic [3:0] t;
    priority if (c >= 7'd90) t = 4'd9;
    else if (c >= 7'd80) t = 4'd8;
    else if (c >= 7'd70) t = 4'd7;
    else if (c >= 7'd60) t = 4'd6;
    else if (c >= 7'd50) t = 4'd5;
    else if (c >= 7'd40) t = 4'd4;
    else if (c >= 7'd30) t = 4'd3;
    else if (c >= 7'd20) t = 4'd2;
    else if (c >= 7'd10) t = 4'd1;
    else                 t = 4'd0;
    return t;
  endfunction

  // Common-anode 7-segment code of a decimal digit.
  function automatic logic [SegW-1:0] seg_code(input logic [3:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/olc_core.sv
// Control state of the occupancy light controller: hold timer, debouncers, event count.
// Depends on olc_pkg.
module olc_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic                           sensor_i,
  input  logic [olc_pkg::NumBtn-1:0]     btn_i,
  input  olc_pkg::olc_cfg_t              cfg_i,
  output olc_pkg::olc_status_t           status_o
);
  import olc_pkg::*;

  logic             light_q, light_d;
  logic             en_q, en_d;
  logic             hold_q, hold_d;
  logic             prev_q, prev_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [CntW-1:0]  pd_q, pd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TickW-1:0] timer_q [NumBtn];
  logic [TickW-1:0] timer_d [NumBtn];
  logic [NumBtn-1:0] await_q, await_d;

  logic [TickW:0]  tick_inc;
  logic [CntW-1:0] pd_inc;
  olc_deb_t        deb_sens, deb_light, deb_rst;

  assign tick_inc  = {1'b0, tick_q} + 17'd1;
  assign pd_inc    = pd_q + 7'd1;
  assign deb_sens  = debounce_step(btn_i[BtnSensor], timer_q[BtnSensor], await_q[BtnSensor],
                                   cfg_i.debounce_ticks);
  assign deb_light = debounce_step(btn_i[BtnLight], timer_q[BtnLight], await_q[BtnLight],
                                   cfg_i.debounce_ticks);
  assign deb_rst   = debounce_step(btn_i[BtnReset], timer_q[BtnReset], await_q[BtnReset],
                                   cfg_i.debounce_ticks);

  always_comb begin
    light_d = light_q;
    en_d    = en_q;
    hold_d  = hold_q;
    tick_d  = tick_q;
    pd_d    = pd_q;
    cnt_d   = cnt_q;
    prev_d  = sensor_i;
    timer_d = timer_q;
    await_d = await_q;
    if (hold_q) begin
      // Hold running: advance the hold only, clear button timers.
      for (int k = 0; k < NumBtn; k++) begin
        timer_d[k] = '0;
      end
      if (sensor_i) begin
        tick_d = '0;
        pd_d   = '0;
      end else if (tick_inc >= {1'b0, cfg_i.period_ticks}) begin
        tick_d = '0;
        if (pd_inc >= cfg_i.period_count) begin
          light_d = 1'b0;
          hold_d  = 1'b0;
          pd_d    = '0;
          cnt_d   = count_inc(cnt_q);
        end else begin
          pd_d = pd_inc;
        end
      end else begin
        tick_d = tick_inc[TickW-1:0];
      end
    end else begin
      timer_d[BtnSensor] = deb_sens.timer;
      await_d[BtnSensor] = deb_sens.await_rel;
      if (deb_sens.fire) begin
        en_d = !en_q;
        if (light_q) begin
          light_d = 1'b0;
          cnt_d   = count_inc(cnt_d);
        end
      end
      if (!en_d) begin
        timer_d[BtnLight] = deb_light.timer;
        await_d[BtnLight] = deb_light.await_rel;
        if (deb_light.fire) begin
          light_d = !light_d;
          if (!light_d) begin
            cnt_d = count_inc(cnt_d);
          end
        end
      end else begin
        timer_d[BtnLight] = '0;
      end
      timer_d[BtnReset] = deb_rst.timer;
      await_d[BtnReset] = deb_rst.await_rel;
      if (deb_rst.fire) begin
        cnt_d   = '0;
        light_d = 1'b0;
      end
      // Rising sensor edge with the sensor enabled starts a hold.
      if (en_d && sensor_i && !prev_q) begin
        light_d = 1'b1;
        hold_d  = 1'b1;
        tick_d  = '0;
        pd_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= 1'b0;
      en_q    <= 1'b1;
      hold_q  <= 1'b0;
      prev_q  <= 1'b0;
      tick_q  <= '0;
      pd_q    <= '0;
      cnt_q   <= '0;
      await_q <= '0;
      for (int k = 0; k < NumBtn; k++) begin
        timer_q[k] <= '0;
      end
    end else if (fire_i) begin
      light_q <= light_d;
      en_q    <= en_d;
      hold_q  <= hold_d;
      prev_q  <= prev_d;
      tick_q  <= tick_d;
      pd_q    <= pd_d;
      cnt_q   <= cnt_d;
      await_q <= await_d;
      timer_q <= timer_d;
    end
  end

  // Report the state as it stands after this item.
  assign status_o.light     = light_d;
  assign status_o.sensor_en = en_d;
  assign status_o.holding   = hold_d;
  assign status_o.count     = cnt_d;

endmodule

>>> rtl/core/olc_display.sv
// Status LED thresholds and 7-segment digit codes of the event count.
// Depends on olc_pkg.
module olc_display (
  input  logic [olc_pkg::CntW-1:0] count_i,
  input  olc_pkg::olc_cfg_t        cfg_i,
  output olc_pkg::olc_disp_t       disp_o
);
  import olc_pkg::*;

  logic [3:0]      tens;
  logic [CntW-1:0] tens_x10;
  logic [CntW-1:0] units;

  assign tens     = tens_of(count_i);
  assign tens_x10 = {tens[3:0], 3'b000} + {2'b00, tens[3:0], 1'b0};
  assign units    = count_i - tens_x10;

  always_comb begin
    disp_o.green  = 1'b0;
    disp_o.yellow = 1'b0;
    disp_o.red    = 1'b0;
    priority if (count_i < cfg_i.green_limit) disp_o.green  = 1'b1;
    else if (count_i < cfg_i.yellow_limit)    disp_o.yellow = 1'b1;
    else                                      disp_o.red    = 1'b1;
    disp_o.seg_tens  = seg_code(tens);
    disp_o.seg_units = seg_code(units[3:0]);
  end

endmodule

>>> rtl/core/occupancy_light_controller.sv
// Top level of the occupancy light controller: config registers, input and result stages.
// Depends on olc_pkg, olc_core and olc_display.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------------
//   input   | in        | in_valid_i / in_stall_o | sensor_level_i, btn_*_i
//   result  | out       | out_valid_o/out_stall_i | light_on_o, sensor_led_o, led_*_o, seg_*_o
//   config  | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One item is one tick of the time base and yields exactly one result item.
// Throughput is one item per cycle while the result is not stalled; the path is the
// input register, then the state update and the result register in one pass.
// Reset is asynchronous, active low; registers return to their reset values
// and the controller state to light off, sensor enabled, no hold, count zero.
// A stalled result holds the result register; the input stage then holds its
// item and raises in_stall_o, so no tick is lost or repeated.
module occupancy_light_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [olc_pkg::IdxW-1:0]      cfg_index_i,
  input  logic [olc_pkg::DataW-1:0]     cfg_data_i,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          sensor_level_i,
  input  logic                          btn_sensor_i,
  input  logic                          btn_light_i,
  input  logic                          btn_reset_i,
  // Result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          light_on_o,
  output logic                          sensor_led_o,
  output logic                          led_green_o,
  output logic                          led_yellow_o,
  output logic                          led_red_o,
  output logic [olc_pkg::SegW-1:0]      seg_tens_o,
  output logic [olc_pkg::SegW-1:0]      seg_units_o
);
  import olc_pkg::*;

  // Configuration registers.
  olc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks   <= PeriodTicksRst;
      cfg_q.period_count   <= PeriodCountRst;
      cfg_q.debounce_ticks <= DebounceTicksRst;
      cfg_q.green_limit    <= GreenLimitRst;
      cfg_q.yellow_limit   <= YellowLimitRst;
    end else if (cfg_we_i) begin
      unique case (olc_reg_e'(cfg_index_i))
        RegPeriodTicks:   cfg_q.period_ticks   <= cfg_data_i;
        RegPeriodCount:   cfg_q.period_count   <= cfg_data_i[CntW-1:0];
        RegDebounceTicks: cfg_q.debounce_ticks <= cfg_data_i;
        RegGreenLimit:    cfg_q.green_limit    <= cfg_data_i[CntW-1:0];
        RegYellowLimit:   cfg_q.yellow_limit   <= cfg_data_i[CntW-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Input stage.
  logic              in_valid_q;
  logic              sensor_q;
  logic [NumBtn-1:0] btn_q;
  logic              out_free;
  logic              fire;
  logic              in_accept;

  // Result register drains or is empty: the input item may advance.
  assign out_free   = !out_valid_o || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload registers: load on accept, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sensor_q          <= sensor_level_i;
      btn_q[BtnSensor]  <= btn_sensor_i;
      btn_q[BtnLight]   <= btn_light_i;
      btn_q[BtnReset]   <= btn_reset_i;
    end
  end

  // State update and display decode.
  olc_status_t status;
  olc_disp_t   disp;

  olc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .sensor_i (sensor_q),
    .btn_i    (btn_q),
    .cfg_i    (cfg_q),
    .status_o (status)
  );

  olc_display u_display (
    .count_i (status.count),
    .cfg_i   (cfg_q),
    .disp_o  (disp)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      light_on_o   <= status.light;
      sensor_led_o <= status.sensor_en;
      led_green_o  <= disp.green;
      led_yellow_o <= disp.yellow;
      led_red_o    <= disp.red;
      seg_tens_o   <= disp.seg_tens;
      seg_units_o  <= disp.seg_units;
    end
  end

`ifndef SYNTHESIS
  // Exactly one status LED is lit on every result.
  a_one_led : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({led_green_o, led_yellow_o, led_red_o}))
    else $error("status LEDs not one-hot");

  // The event count saturates and never leaves 0..99.
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (status.count <= CountMax))
    else $error("event count above saturation");

  // An auto hold always keeps the light on.
  a_hold_light : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && status.holding) |=> (out_valid_o && light_on_o))
    else $error("hold running with light off");

  // The input stage stalls only while the result register is full and stalled.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && in_valid_q))
    else $error("input stalled without a stalled result");
`endif

endmodule
